// ===== sv/ipg_pkg.sv =====
// Shared types and constants for the integer partition generator.
// Used by the top, the controller and the datapath; depends on nothing else.
package ipg_pkg;

  localparam int MAX_N       = 64;
  localparam int PTR_W       = $clog2(MAX_N);
  localparam int DEPTH_W     = PTR_W + 1;
  localparam int PART_W      = 7;
  localparam int SEQ_W       = 21;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 32;

  localparam logic [DEPTH_W-1:0] MAX_DEPTH = DEPTH_W'(MAX_N);

  // Input selector carried on in_tuser.
  localparam logic FUNC_START   = 1'b0;
  localparam logic FUNC_ADVANCE = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FILL,
    S_RD_TOP,
    S_RD_SEC,
    S_CALC,
    S_SPLIT,
    S_EMIT,
    S_DONE
  } ipg_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear_start;  // start with a nonzero total
    logic clear_zero;   // start with a zero total
    logic set_fin;      // advance when no partition is left
    logic fill_push;
    logic rd_top;
    logic rd_sec;
    logic calc;
    logic split_step;
    logic emit_run;
    logic load_done;
  } ipg_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic total_zero;
    logic adv_ok;
    logic fill_last;
    logic merge;
    logic split_more;
    logic emit_done;
    logic out_free;
  } ipg_stat_t;

endpackage

// ===== sv/integer_partition_generator.sv =====
// Integer partition generator: enumerates partitions of a total, smallest part first.
// Start of n: fills the stack with n ones, then emits them as the first partition.
// Advance: reads the top two parts from the stack, merges them or splits the remainder
// into further parts, then emits the parts one per cycle while the output does not stall.
// Done: the done result is loaded once the output register is free; one request at a time.
// Synchronous active-low reset clears controller, depth, counter, emit state and output valid and sets finished.
module integer_partition_generator
  import ipg_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [6:0] total, [7] unused
  input  logic                   in_tuser,   // [0] func
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [6:0] part, [27:7] seq_number, [31:28] zero
  output logic                   out_tlast,
  output logic                   out_tuser   // [0] done_res
);

  ipg_cmd_t          cmd;
  ipg_stat_t         stat;
  logic [PART_W-1:0] out_part;
  logic [SEQ_W-1:0]  out_seq;

  ipg_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_tvalid),
    .in_func (in_tuser),
    .stat    (stat),
    .in_ready(in_tready),
    .cmd     (cmd)
  );

  ipg_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_total (in_tdata[PART_W-1:0]),
    .out_ready(out_tready),
    .stat     (stat),
    .out_valid(out_tvalid),
    .out_part (out_part),
    .out_seq  (out_seq),
    .out_last (out_tlast),
    .out_done (out_tuser)
  );

  assign out_tdata = {(OUT_TDATA_W - PART_W - SEQ_W)'(0), out_seq, out_part};

  // The controller handles one transaction at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted while a transaction was still in work");

  a_done_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast && (out_part == '0) && (out_seq == '0))
    else $error("done result with a part, a sequence number or no last mark");

  a_part_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> (out_part != '0) && (out_seq != '0))
    else $error("partition result with a zero part or sequence number");

endmodule

// ===== sv/ipg_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing; used for the part stack.
module ipg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/ipg_ctrl.sv =====
// Controller state machine of the integer partition generator.
// Depends on ipg_pkg; drives the datapath through ipg_cmd_t.
module ipg_ctrl
  import ipg_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_func,
  input  ipg_stat_t stat,
  output logic      in_ready,
  output ipg_cmd_t  cmd
);

  ipg_state_t state_r, state_nxt;
  logic       accept;

  assign accept = in_valid && (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_func == FUNC_START) begin
            state_nxt = stat.total_zero ? S_DONE : S_FILL;
          end else begin
            state_nxt = stat.adv_ok ? S_RD_TOP : S_DONE;
          end
        end
      end
      S_FILL: begin
        if (stat.fill_last) state_nxt = S_EMIT;
      end
      S_RD_TOP: state_nxt = S_RD_SEC;
      S_RD_SEC: state_nxt = S_CALC;
      S_CALC:   state_nxt = stat.merge ? S_EMIT : S_SPLIT;
      S_SPLIT: begin
        if (!stat.split_more) state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (stat.emit_done) state_nxt = S_IDLE;
      end
      S_DONE: begin
        if (stat.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (accept) begin
          if (in_func == FUNC_START) begin
            cmd.clear_zero  = stat.total_zero;
            cmd.clear_start = !stat.total_zero;
          end else begin
            cmd.set_fin = !stat.adv_ok;
          end
        end
      end
      S_FILL:   cmd.fill_push  = 1'b1;
      S_RD_TOP: cmd.rd_top     = 1'b1;
      S_RD_SEC: cmd.rd_sec     = 1'b1;
      S_CALC:   cmd.calc       = 1'b1;
      S_SPLIT:  cmd.split_step = 1'b1;
      S_EMIT:   cmd.emit_run   = 1'b1;
      S_DONE:   cmd.load_done  = stat.out_free;
      default:  cmd            = '0;
    endcase
  end

endmodule

// ===== sv/ipg_dp.sv =====
// Datapath of the integer partition generator: part stack, counters,
// split arithmetic and the output register. Depends on ipg_pkg and ipg_ram.
module ipg_dp
  import ipg_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  ipg_cmd_t          cmd,
  input  logic [PART_W-1:0] in_total,
  input  logic              out_ready,
  output ipg_stat_t         stat,
  output logic              out_valid,
  output logic [PART_W-1:0] out_part,
  output logic [SEQ_W-1:0]  out_seq,
  output logic              out_last,
  output logic              out_done
);

  logic [DEPTH_W-1:0] depth_r, depth_nxt;
  logic [SEQ_W-1:0]   cnt_r, cnt_nxt;
  logic               fin_r, fin_nxt;
  logic [DEPTH_W-1:0] n_r, n_nxt;
  logic [PART_W-1:0]  top_r;
  logic [PART_W:0]    x_r;
  logic [PART_W-1:0]  r_r, r_nxt;
  logic [DEPTH_W-1:0] emit_idx_r, emit_idx_nxt;
  logic               rd_pend_r, rd_pend_nxt;
  logic               pend_last_r;
  logic               out_valid_r;
  logic [PART_W-1:0]  out_part_r;
  logic [SEQ_W-1:0]   out_seq_r;
  logic               out_last_r;
  logic               out_done_r;

  logic               we, re;
  logic [PTR_W-1:0]   waddr, raddr;
  logic [PART_W-1:0]  wdata, rdata;

  logic [DEPTH_W-1:0] depth_m1, depth_m2;
  logic [PART_W:0]    x_c, sum_c;
  logic [PART_W-1:0]  y_c;
  logic [PART_W+1:0]  two_x;
  logic               out_free, load_part, issue;

  ipg_ram #(
    .WIDTH(PART_W),
    .DEPTH(MAX_N)
  ) u_stack (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .re   (re),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign depth_m1 = depth_r - DEPTH_W'(1);
  assign depth_m2 = depth_r - DEPTH_W'(2);

  // The second part arrives from the stack in the calc cycle; top was captured before.
  assign x_c   = {1'b0, rdata} + (PART_W+1)'(1);
  assign y_c   = (top_r == '0) ? '0 : top_r - PART_W'(1);
  assign sum_c = x_c + {1'b0, y_c};
  assign two_x = {x_r, 1'b0};

  assign out_free  = !out_valid_r || out_ready;
  assign load_part = rd_pend_r && out_free;
  assign issue     = cmd.emit_run && (emit_idx_r != depth_r) && (!rd_pend_r || load_part);

  assign stat.total_zero = (in_total == '0);
  assign stat.adv_ok     = !fin_r && (depth_r >= DEPTH_W'(2));
  assign stat.fill_last  = ((depth_r + DEPTH_W'(1)) == n_r);
  assign stat.merge      = ({1'b0, y_c} < x_c);
  assign stat.split_more = ({2'b0, r_r} >= two_x) && (depth_r < MAX_DEPTH);
  assign stat.emit_done  = (emit_idx_r == depth_r) && !rd_pend_r;
  assign stat.out_free   = out_free;

  // Stack read port: the two operands of an advance, or the parts being emitted.
  always_comb begin
    re    = issue || cmd.rd_top || cmd.rd_sec;
    raddr = emit_idx_r[PTR_W-1:0];
    if (cmd.rd_top) begin
      raddr = depth_m1[PTR_W-1:0];
    end else if (cmd.rd_sec) begin
      raddr = depth_m2[PTR_W-1:0];
    end
  end

  // Stack write port and stack bookkeeping.
  always_comb begin
    we        = 1'b0;
    waddr     = depth_r[PTR_W-1:0];
    wdata     = PART_W'(1);
    depth_nxt = depth_r;
    cnt_nxt   = cnt_r;
    fin_nxt   = fin_r;
    n_nxt     = n_r;
    r_nxt     = r_r;
    if (cmd.clear_start) begin
      depth_nxt = '0;
      cnt_nxt   = SEQ_W'(1);
      fin_nxt   = 1'b0;
      n_nxt     = (in_total > PART_W'(MAX_N)) ? MAX_DEPTH : DEPTH_W'(in_total);
    end
    if (cmd.clear_zero) begin
      depth_nxt = '0;
      cnt_nxt   = '0;
      fin_nxt   = 1'b1;
    end
    if (cmd.set_fin) begin
      fin_nxt = 1'b1;
    end
    if (cmd.fill_push) begin
      we        = 1'b1;
      depth_nxt = depth_r + DEPTH_W'(1);
    end
    if (cmd.calc) begin
      we        = 1'b1;
      waddr     = depth_m2[PTR_W-1:0];
      wdata     = stat.merge ? sum_c[PART_W-1:0] : x_c[PART_W-1:0];
      depth_nxt = depth_m1;
      cnt_nxt   = cnt_r + SEQ_W'(1);
      r_nxt     = y_c;
    end
    if (cmd.split_step) begin
      we = (depth_r < MAX_DEPTH);
      if (stat.split_more) begin
        wdata = x_r[PART_W-1:0];
        r_nxt = r_r - x_r[PART_W-1:0];
      end else begin
        wdata = r_r;
      end
      if (we) depth_nxt = depth_r + DEPTH_W'(1);
    end
  end

  always_comb begin
    emit_idx_nxt = '0;
    rd_pend_nxt  = rd_pend_r;
    if (cmd.emit_run) begin
      emit_idx_nxt = issue ? emit_idx_r + DEPTH_W'(1) : emit_idx_r;
    end
    if (issue) begin
      rd_pend_nxt = 1'b1;
    end else if (load_part) begin
      rd_pend_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r     <= '0;
      cnt_r       <= '0;
      fin_r       <= 1'b1;
      emit_idx_r  <= '0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      depth_r    <= depth_nxt;
      cnt_r      <= cnt_nxt;
      fin_r      <= fin_nxt;
      emit_idx_r <= emit_idx_nxt;
      rd_pend_r  <= rd_pend_nxt;
      if (load_part || cmd.load_done) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    n_r <= n_nxt;
    r_r <= r_nxt;
    if (cmd.rd_sec) top_r <= rdata;
    if (cmd.calc) x_r <= x_c;
    if (issue) pend_last_r <= ((emit_idx_r + DEPTH_W'(1)) == depth_r);
    if (load_part) begin
      out_part_r <= rdata;
      out_seq_r  <= cnt_r;
      out_last_r <= pend_last_r;
      out_done_r <= 1'b0;
    end else if (cmd.load_done) begin
      out_part_r <= '0;
      out_seq_r  <= '0;
      out_last_r <= 1'b1;
      out_done_r <= 1'b1;
    end
  end

  assign out_valid = out_valid_r;
  assign out_part  = out_part_r;
  assign out_seq   = out_seq_r;
  assign out_last  = out_last_r;
  assign out_done  = out_done_r;

endmodule
